// ===== rtl/assert_macros.svh =====
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BSA_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("allocator assertion failed");

// expression must never be true outside reset
`define BSA_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("allocator forbidden condition seen");

`endif

// ===== rtl/bsa_pkg.sv =====
// shared types and constants of the bitmap slot allocator
`timescale 1ns / 1ps
`default_nettype none
package bsa_pkg;

  localparam int DIV_DW = 24;
  localparam int DIV_VW = 13;
  localparam int DIV_CW = 5;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOROOM = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic CFG_IDX_COUNT = 1'b0;
  localparam logic CFG_IDX_BYTES = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/bsa_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/bsa_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bsa_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bsa_pkg::div_req_t req,
  output bsa_pkg::div_rsp_t      rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [bsa_pkg::DIV_CW-1:0]     cnt_r, cnt_nxt;
  logic [bsa_pkg::DIV_DW-1:0]     dvd_r, dvd_nxt;
  logic [bsa_pkg::DIV_VW-1:0]     rem_r, rem_nxt;
  logic [bsa_pkg::DIV_VW-1:0]     dvs_r, dvs_nxt;
  logic [bsa_pkg::DIV_VW:0]       rem_sh;
  logic [bsa_pkg::DIV_VW:0]       rem_sub;
  logic                           ge;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[bsa_pkg::DIV_DW-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[bsa_pkg::DIV_DW-2:0], ge};
      rem_nxt = ge ? rem_sub[bsa_pkg::DIV_VW-1:0] : rem_sh[bsa_pkg::DIV_VW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bsa_pkg::DIV_CW'(bsa_pkg::DIV_DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;

endmodule
`default_nettype wire

// ===== rtl/bitmap_slot_allocator_top.sv =====
// top level of the bitmap slot allocator: control sequencer, owner map, config port
`timescale 1ns / 1ps
`default_nettype none
// Slot allocator over one region whose owner map (one tag per slot, 0 = free)
// sits in a single-port-read, single-port-write ram with a registered read.
// One word is worked on at a time and each gives exactly one result word.
// After reset the map is cleared by a sweep over all MAX_SLOTS slots during
// which no input word is taken (config writes are still taken). Steps per
// word: init = a division, then a rewrite of the whole map; free = a
// division, a read of the tag of the slot to free, then a pass that clears
// the run; alloc = the size check and a division, then a streaming scan of
// the map at one slot per cycle (at most two passes of slot_count slots),
// then the neighbour tag reads and a write of each slot of the new run. The
// scan and the clearing passes are bound by the single ram read port; the
// divisions by the bit-serial divider. A result may wait at the output while
// the next word is already accepted.
module bitmap_slot_allocator_top #(
  parameter int MAX_SLOTS = 1024,
  parameter int TAG_BITS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // req_bytes[22:0], free_offset[44:23], zero pad
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // alloc_offset[21:0], zero pad
  output logic      [1:0]  out_tuser,  // status[1:0]
  // config port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int SW = $clog2(MAX_SLOTS);       // slot index width
  localparam int CW = $clog2(MAX_SLOTS + 1);   // slot count width
  localparam logic [TAG_BITS-1:0] InitTag = TAG_BITS'(5);

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;   // map sweep (reset clear or init)
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FCHK = 4'd2;   // free space check
  localparam logic [3:0] S_DIV  = 4'd3;   // waiting on divider
  localparam logic [3:0] S_SCAN = 4'd4;   // free run search
  localparam logic [3:0] S_NBR  = 4'd5;   // neighbour tag reads
  localparam logic [3:0] S_WR   = 4'd6;   // tag the new run
  localparam logic [3:0] S_FRD  = 4'd7;   // read tag of slot to free
  localparam logic [3:0] S_FTAG = 4'd8;
  localparam logic [3:0] S_FCLR = 4'd9;   // clear the run
  localparam logic [3:0] S_RESP = 4'd10;

  // new tag: left plus one, stepping past the right tag and zero
  function automatic logic [TAG_BITS-1:0] pick_tag(input logic [TAG_BITS-1:0] left,
                                                   input logic [TAG_BITS-1:0] right);
    logic [TAG_BITS-1:0] c;
    c = left + 1'b1;
    for (int g = 0; g < 4; g++) begin
      if (c == right || c == '0) begin
        c = c + 1'b1;
      end
    end
    return c;
  endfunction

  logic [3:0]           state_r, state_nxt;
  logic [10:0]          cnt_cfg_r, cnt_cfg_nxt;
  logic [12:0]          bytes_cfg_r, bytes_cfg_nxt;
  logic [1:0]           func_r, func_nxt;
  logic [22:0]          req_r, req_nxt;
  logic [CW-1:0]        used_r, used_nxt;
  logic [SW-1:0]        search_r, search_nxt;
  logic [CW-1:0]        lead_r, lead_nxt;
  logic                 init_r, init_nxt;
  logic [SW-1:0]        w_r, w_nxt;
  logic [CW-1:0]        need_r, need_nxt;
  logic [CW-1:0]        start_r, start_nxt;
  logic [CW-1:0]        q_r, q_nxt;
  logic [SW-1:0]        qd_r, qd_nxt;
  logic                 rv_r, rv_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  logic [CW-1:0]        begin_r, begin_nxt;
  logic                 phase_r, phase_nxt;
  logic [CW-1:0]        x_r, x_nxt;
  logic [1:0]           nb_r, nb_nxt;
  logic [TAG_BITS-1:0]  left_r, left_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [1:0]           res_st_r, res_st_nxt;
  logic [21:0]          res_ofs_r, res_ofs_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_st_r, out_st_nxt;
  logic [21:0]          out_ofs_r, out_ofs_nxt;

  // effective config
  logic [CW-1:0]        cnt_eff;
  logic [12:0]          bs_eff;

  // ram ports
  logic                 ram_we;
  logic [SW-1:0]        ram_waddr;
  logic [TAG_BITS-1:0]  ram_wdata;
  logic [SW-1:0]        ram_raddr;
  logic [TAG_BITS-1:0]  ram_rdata;

  bsa_pkg::div_req_t    div_req;
  bsa_pkg::div_rsp_t    div_rsp;

  // scratch
  logic                 in_acc;
  logic                 cfg_wr;
  logic [31:0]          free_bytes;
  logic [CW:0]          xn;
  logic [CW-1:0]        run_b;
  logic [CW-1:0]        run_l;
  logic                 issue;
  logic [23:0]          prod;
  logic [CW-1:0]        lead_q;

  assign cnt_eff = (32'(cnt_cfg_r) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cnt_cfg_r);
  assign bs_eff  = (bytes_cfg_r == '0) ? 13'd1 : bytes_cfg_r;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {2'b00, out_ofs_r};

  // config port: writes land on psel & penable & pwrite, no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      bsa_pkg::CFG_IDX_COUNT: cfg_prdata = {21'd0, cnt_cfg_r};
      default:                cfg_prdata = {19'd0, bytes_cfg_r};
    endcase
  end

  always_comb begin
    cnt_cfg_nxt   = cnt_cfg_r;
    bytes_cfg_nxt = bytes_cfg_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        bsa_pkg::CFG_IDX_COUNT: cnt_cfg_nxt   = cfg_pwdata[10:0];
        bsa_pkg::CFG_IDX_BYTES: bytes_cfg_nxt = cfg_pwdata[12:0];
        default:                cnt_cfg_nxt   = cnt_cfg_r;
      endcase
    end
  end

  // owner map
  bsa_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared divider for slot rounding, offset to slot, init lead count
  bsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign free_bytes = (used_r >= cnt_eff) ? 32'd0 : 32'(cnt_eff - used_r) * 32'(bs_eff);
  assign xn         = (CW + 1)'(x_r) + (CW + 1)'(need_r);
  // only the low 22 bits of the offset are kept
  assign prod       = 24'(x_r) * 24'(bs_eff);
  assign lead_q     = div_rsp.quot[CW-1:0];
  assign issue      = (q_r < cnt_eff);

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    req_nxt     = req_r;
    used_nxt    = used_r;
    search_nxt  = search_r;
    lead_nxt    = lead_r;
    init_nxt    = init_r;
    w_nxt       = w_r;
    need_nxt    = need_r;
    start_nxt   = start_r;
    q_nxt       = q_r;
    qd_nxt      = qd_r;
    rv_nxt      = 1'b0;
    len_nxt     = len_r;
    begin_nxt   = begin_r;
    phase_nxt   = phase_r;
    x_nxt       = x_r;
    nb_nxt      = nb_r;
    left_nxt    = left_r;
    tag_nxt     = tag_r;
    k_nxt       = k_r;
    n_nxt       = n_r;
    res_st_nxt  = res_st_r;
    res_ofs_nxt = res_ofs_r;
    ram_we      = 1'b0;
    ram_waddr   = w_r;
    ram_wdata   = '0;
    ram_raddr   = q_r[SW-1:0];
    run_b       = begin_r;
    run_l       = len_r;
    div_req.start    = 1'b0;
    div_req.dividend = 24'(req_r) + 24'(bs_eff) - 24'd1;
    div_req.divisor  = bs_eff;

    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_ofs_nxt   = out_ofs_r;

    case (state_r)
      S_CLR: begin
        // sweep the whole map; init puts the leading tag on slots below lead
        ram_we    = 1'b1;
        ram_waddr = w_r;
        ram_wdata = (init_r && (CW'(w_r) < lead_r)) ? InitTag : '0;
        w_nxt     = w_r + 1'b1;
        if (w_r == SW'(MAX_SLOTS - 1)) begin
          w_nxt = '0;
          if (init_r) begin
            init_nxt   = 1'b0;
            res_st_nxt = bsa_pkg::ST_DONE;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          func_nxt    = in_tuser;
          req_nxt     = in_tdata[22:0];
          res_ofs_nxt = '0;
          case (in_tuser)
            bsa_pkg::FUNC_ALLOC: begin
              if (in_tdata[22:0] == '0) begin
                res_st_nxt = bsa_pkg::ST_BAD;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_FCHK;
              end
            end
            bsa_pkg::FUNC_FREE: begin
              div_req.start    = 1'b1;
              div_req.dividend = 24'(in_tdata[44:23]);
              state_nxt        = S_DIV;
            end
            bsa_pkg::FUNC_INIT: begin
              div_req.start    = 1'b1;
              div_req.dividend = 24'(cnt_eff) + 24'(bs_eff) - 24'd1;
              state_nxt        = S_DIV;
            end
            default: begin
              res_st_nxt = bsa_pkg::ST_BAD;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end

      S_FCHK: begin
        if (free_bytes < 32'(req_r)) begin
          res_st_nxt = bsa_pkg::ST_NOROOM;
          state_nxt  = S_RESP;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          case (func_r)
            bsa_pkg::FUNC_ALLOC: begin
              // free check bounds the rounded size by the free slot count
              need_nxt = div_rsp.quot[CW-1:0];
              if ((CW + 1)'(search_r) + 1'b1 >= (CW + 1)'(cnt_eff)) begin
                start_nxt = '0;
                q_nxt     = '0;
              end else begin
                start_nxt = CW'(search_r) + 1'b1;
                q_nxt     = CW'(search_r) + 1'b1;
              end
              len_nxt   = '0;
              phase_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            bsa_pkg::FUNC_FREE: begin
              if (div_rsp.quot >= 24'(cnt_eff)) begin
                res_st_nxt = bsa_pkg::ST_BAD;
                state_nxt  = S_RESP;
              end else begin
                x_nxt     = div_rsp.quot[CW-1:0];
                state_nxt = S_FRD;
              end
            end
            default: begin
              lead_nxt   = lead_q;
              used_nxt   = lead_q;
              search_nxt = (lead_q != '0) ? SW'(lead_q - 1'b1) : '0;
              init_nxt   = 1'b1;
              w_nxt      = '0;
              state_nxt  = S_CLR;
            end
          endcase
        end
      end

      S_SCAN: begin
        // streaming read, one slot per cycle; data for qd_r arrives in the cycle after its read
        ram_raddr = q_r[SW-1:0];
        rv_nxt    = issue;
        qd_nxt    = q_r[SW-1:0];
        q_nxt     = issue ? q_r + 1'b1 : q_r;
        if (rv_r) begin
          if (ram_rdata == '0) begin
            run_b     = (len_r == '0) ? CW'(qd_r) : begin_r;
            run_l     = len_r + 1'b1;
            begin_nxt = run_b;
            len_nxt   = run_l;
            if (run_l == need_r) begin
              rv_nxt = 1'b0;
              // second pass only takes runs that start before the first pass did
              if (!phase_r || run_b < start_r) begin
                x_nxt     = run_b;
                nb_nxt    = '0;
                state_nxt = S_NBR;
              end else begin
                res_st_nxt = bsa_pkg::ST_NOROOM;
                state_nxt  = S_RESP;
              end
            end
          end else begin
            len_nxt = '0;
          end
        end else if (!issue) begin
          if (!phase_r) begin
            phase_nxt = 1'b1;
            q_nxt     = '0;
            len_nxt   = '0;
          end else begin
            res_st_nxt = bsa_pkg::ST_NOROOM;
            state_nxt  = S_RESP;
          end
        end
      end

      S_NBR: begin
        case (nb_r)
          2'd0: begin
            ram_raddr = SW'(x_r - 1'b1);
            nb_nxt    = 2'd1;
          end
          2'd1: begin
            left_nxt  = (x_r != '0) ? ram_rdata : '0;
            ram_raddr = xn[SW-1:0];
            nb_nxt    = 2'd2;
          end
          default: begin
            tag_nxt   = pick_tag(left_r, (xn < (CW + 1)'(cnt_eff)) ? ram_rdata : '0);
            k_nxt     = '0;
            state_nxt = S_WR;
          end
        endcase
      end

      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = SW'(x_r + k_r);
        ram_wdata = tag_r;
        k_nxt     = k_r + 1'b1;
        if (k_r + 1'b1 == need_r) begin
          search_nxt  = SW'(xn - 1'b1);
          used_nxt    = used_r + need_r;
          res_ofs_nxt = prod[21:0];
          res_st_nxt  = bsa_pkg::ST_DONE;
          state_nxt   = S_RESP;
        end
      end

      S_FRD: begin
        ram_raddr = x_r[SW-1:0];
        state_nxt = S_FTAG;
      end

      S_FTAG: begin
        if (ram_rdata == '0) begin
          res_st_nxt = bsa_pkg::ST_BAD;
          state_nxt  = S_RESP;
        end else begin
          tag_nxt   = ram_rdata;
          q_nxt     = x_r;
          n_nxt     = '0;
          state_nxt = S_FCLR;
        end
      end

      S_FCLR: begin
        // read ahead one slot while clearing the previous one
        ram_raddr = q_r[SW-1:0];
        rv_nxt    = issue;
        qd_nxt    = q_r[SW-1:0];
        q_nxt     = issue ? q_r + 1'b1 : q_r;
        if (rv_r && ram_rdata == tag_r) begin
          ram_we    = 1'b1;
          ram_waddr = qd_r;
          ram_wdata = '0;
          n_nxt     = n_r + 1'b1;
        end else if (rv_r || !issue) begin
          rv_nxt     = 1'b0;
          used_nxt   = (used_r > n_r) ? used_r - n_r : '0;
          res_st_nxt = bsa_pkg::ST_DONE;
          state_nxt  = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_ofs_nxt   = res_ofs_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_cfg_r   <= 11'd1024;
      bytes_cfg_r <= 13'd16;
      used_r      <= '0;
      search_r    <= '0;
      lead_r      <= '0;
      init_r      <= 1'b0;
      w_r         <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_cfg_r   <= cnt_cfg_nxt;
      bytes_cfg_r <= bytes_cfg_nxt;
      used_r      <= used_nxt;
      search_r    <= search_nxt;
      lead_r      <= lead_nxt;
      init_r      <= init_nxt;
      w_r         <= w_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r    <= func_nxt;
    req_r     <= req_nxt;
    need_r    <= need_nxt;
    start_r   <= start_nxt;
    q_r       <= q_nxt;
    qd_r      <= qd_nxt;
    len_r     <= len_nxt;
    begin_r   <= begin_nxt;
    phase_r   <= phase_nxt;
    x_r       <= x_nxt;
    nb_r      <= nb_nxt;
    left_r    <= left_nxt;
    tag_r     <= tag_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
    res_st_r  <= res_st_nxt;
    res_ofs_r <= res_ofs_nxt;
    out_st_r  <= out_st_nxt;
    out_ofs_r <= out_ofs_nxt;
  end

  `include "assert_macros.svh"

  // one word at a time: after an accept the input side is closed
  `BSA_ASSERT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  // only a successful alloc carries an offset
  `BSA_ASSERT(a_ofs_zero, clk, rst_n, (out_tvalid && out_tuser != bsa_pkg::ST_DONE) |-> !(|out_tdata))
  // the map is never written while the sequencer is idle
  `BSA_NEVER(a_no_idle_write, clk, rst_n, (state_r == S_IDLE) && ram_we)

endmodule
`default_nettype wire
